### rtl/core/jsc_pkg.sv
// ----------------------------------------------------------------------------
// JPEG scan scanner package
// Shared types and constants for the start-of-scan header parser and the
// entropy-coded data scanner.
// ----------------------------------------------------------------------------
package jsc_pkg;

	// Field widths of the byte and result channels.
	localparam int BYTE_W   = 8;
	localparam int EVENT_W  = 4;
	localparam int VALUE_W  = 24;
	localparam int NIBBLE_W = 4;

	// Width of the saturating segment length counter (16 to 32).
	localparam int SEG_BITS = 24;

	// Header bookkeeping widths.
	localparam int HDR_W  = 16;
	localparam int COMP_W = 8;

	// Fixed header bytes: length (2), count, spectral start, spectral end, approximation.
	localparam logic [HDR_W-1:0] HDR_FIXED_BYTES = 16'd6;

	// Marker bytes of the entropy-coded data.
	localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
	localparam logic [BYTE_W-1:0] STUFF_BYTE    = 8'h00;
	localparam logic [4:0]        RST_TOP_BITS  = 5'b11010;

	// Result queue depth; two results may enter per transaction.
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Parser phase.
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_LEN_LO  = 4'd1,
		PH_COUNT   = 4'd2,
		PH_COMP    = 4'd3,
		PH_SS      = 4'd4,
		PH_SE      = 4'd5,
		PH_APPROX  = 4'd6,
		PH_SKIP    = 4'd7,
		PH_ENTROPY = 4'd8
	} jsc_phase_t;

	// Result event codes.
	typedef enum logic [EVENT_W-1:0] {
		EV_COUNT     = 4'd0,
		EV_SELECTOR  = 4'd1,
		EV_TABLES    = 4'd2,
		EV_SPEC_ST   = 4'd3,
		EV_SPEC_END  = 4'd4,
		EV_APPROX    = 4'd5,
		EV_SKIPPED   = 4'd6,
		EV_SEGMENT   = 4'd7,
		EV_RESTART   = 4'd8,
		EV_END_MARK  = 4'd9,
		EV_EOF_ERR   = 4'd10,
		EV_TRUNCATED = 4'd11
	} jsc_event_t;

	// One result item.
	typedef struct packed {
		jsc_event_t          event_res;
		logic [VALUE_W-1:0]  value;
		logic [NIBBLE_W-1:0] high_nibble;
		logic [NIBBLE_W-1:0] low_nibble;
		logic                scan_done;
	} jsc_result_t;

endpackage

### rtl/core/jsc_in_if.sv
// ----------------------------------------------------------------------------
// JPEG scan scanner byte channel
// Valid/ready channel carrying one file byte and its framing flags.
// ----------------------------------------------------------------------------
interface jsc_in_if import jsc_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] data_byte;
	logic              scan_start;
	logic              end_of_data;

	modport source (output valid, output data_byte, output scan_start, output end_of_data,
		input ready);
	modport sink (input valid, input data_byte, input scan_start, input end_of_data,
		output ready);
endinterface

### rtl/core/jsc_out_if.sv
// ----------------------------------------------------------------------------
// JPEG scan scanner result channel
// Valid/ready channel carrying one parser event.
// ----------------------------------------------------------------------------
interface jsc_out_if import jsc_pkg::*;;
	logic                valid;
	logic                ready;
	logic [EVENT_W-1:0]  event_res;
	logic [VALUE_W-1:0]  value;
	logic [NIBBLE_W-1:0] high_nibble;
	logic [NIBBLE_W-1:0] low_nibble;
	logic                scan_done;

	modport source (output valid, output event_res, output value, output high_nibble,
		output low_nibble, output scan_done, input ready);
	modport sink (input valid, input event_res, input value, input high_nibble,
		input low_nibble, input scan_done, output ready);
endinterface

### rtl/core/jpeg_scan_header_entropy_scanner.sv
// ----------------------------------------------------------------------------
// JPEG start-of-scan header parser and entropy data scanner
// Throughput: one byte per cycle while the result queue holds two results or
// fewer; a byte may raise two results, and the port moves one per cycle,
// so the four-entry result queue, which registers each result, sets the pace.
// Reset: the parser returns to idle and the result queue empties at once.
// Parses the scan header byte by byte, reports its fields, skips surplus
// header bytes, then counts entropy-coded bytes up to restart and end markers.
// ----------------------------------------------------------------------------
module jpeg_scan_header_entropy_scanner import jsc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	jsc_in_if.sink    byte_stream,
	jsc_out_if.source result_stream
);

	localparam logic [SEG_BITS-1:0] SEG_MAX   = {SEG_BITS{1'b1}};
	localparam logic [VALUE_W-1:0]  VALUE_MAX = {VALUE_W{1'b1}};

	// Parser state.
	jsc_phase_t          phase_q, phase_nxt;
	logic [HDR_W-1:0]    hdr_len_q, hdr_len_nxt;
	logic [HDR_W-1:0]    hdr_used_q, hdr_used_nxt;
	logic [COMP_W-1:0]   comp_left_q, comp_left_nxt;
	logic                second_q, second_nxt;
	logic [HDR_W-1:0]    skip_left_q, skip_left_nxt;
	logic [SEG_BITS-1:0] seg_len_q, seg_len_nxt;
	logic                after_ff_q, after_ff_nxt;

	// Results raised by the current byte.
	jsc_result_t res_slot [2];
	logic [1:0]  res_cnt;

	// Result queue.
	jsc_result_t        queue_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               in_acc, out_acc;
	logic [BYTE_W-1:0]  b;
	logic [HDR_W-1:0]   skip_calc;

	// Saturating segment length to result value.
	function automatic logic [VALUE_W-1:0] seg_to_value(input logic [SEG_BITS-1:0] s);
		logic [SEG_BITS+VALUE_W-1:0] wide;
		wide = {{VALUE_W{1'b0}}, s};
		if (wide > {{SEG_BITS{1'b0}}, VALUE_MAX})
			return VALUE_MAX;
		return wide[VALUE_W-1:0];
	endfunction

	// Saturating add to the segment length.
	function automatic logic [SEG_BITS-1:0] seg_add(input logic [SEG_BITS-1:0] s,
		input logic [1:0] k);
		logic [SEG_BITS:0] sum;
		sum = {1'b0, s} + {{(SEG_BITS-1){1'b0}}, k};
		if (sum > {1'b0, SEG_MAX})
			return SEG_MAX;
		return sum[SEG_BITS-1:0];
	endfunction

	function automatic jsc_result_t make_res(input jsc_event_t ev,
		input logic [VALUE_W-1:0] val, input logic [NIBBLE_W-1:0] hi,
		input logic [NIBBLE_W-1:0] lo, input logic done);
		jsc_result_t r;
		r.event_res   = ev;
		r.value       = val;
		r.high_nibble = hi;
		r.low_nibble  = lo;
		r.scan_done   = done;
		return r;
	endfunction

	// Handshakes.
	assign in_acc  = byte_stream.valid && byte_stream.ready;
	assign out_acc = result_stream.valid && result_stream.ready;
	assign byte_stream.ready = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
	assign b = byte_stream.data_byte;
	assign skip_calc = (hdr_len_q > hdr_used_q) ? (hdr_len_q - hdr_used_q) : '0;

	// Next parser state and results for the byte on the input.
	always_comb begin
		phase_nxt     = phase_q;
		hdr_len_nxt   = hdr_len_q;
		hdr_used_nxt  = hdr_used_q;
		comp_left_nxt = comp_left_q;
		second_nxt    = second_q;
		skip_left_nxt = skip_left_q;
		seg_len_nxt   = seg_len_q;
		after_ff_nxt  = after_ff_q;
		res_slot[0]   = '0;
		res_slot[1]   = '0;
		res_cnt       = 2'd0;

		if (byte_stream.scan_start) begin
			phase_nxt     = PH_LEN_LO;
			hdr_len_nxt   = {b, 8'h00};
			hdr_used_nxt  = HDR_FIXED_BYTES;
			comp_left_nxt = '0;
			second_nxt    = 1'b0;
			skip_left_nxt = '0;
			seg_len_nxt   = '0;
			after_ff_nxt  = 1'b0;
		end else begin
			unique case (phase_q)
				PH_IDLE: begin
				end
				PH_LEN_LO: begin
					hdr_len_nxt = {hdr_len_q[HDR_W-1:BYTE_W], b};
					phase_nxt   = PH_COUNT;
				end
				PH_COUNT: begin
					comp_left_nxt = b;
					hdr_used_nxt  = HDR_FIXED_BYTES + {7'd0, b, 1'b0};
					second_nxt    = 1'b0;
					res_slot[0]   = make_res(EV_COUNT, VALUE_W'(b), '0, '0, 1'b0);
					res_cnt       = 2'd1;
					phase_nxt     = (b != '0) ? PH_COMP : PH_SS;
				end
				PH_COMP: begin
					if (!second_q) begin
						res_slot[0] = make_res(EV_SELECTOR, VALUE_W'(b), '0, '0, 1'b0);
						second_nxt  = 1'b1;
					end else begin
						res_slot[0]   = make_res(EV_TABLES, VALUE_W'(b), b[7:4], b[3:0], 1'b0);
						second_nxt    = 1'b0;
						comp_left_nxt = comp_left_q - 1'b1;
						if (comp_left_q == COMP_W'(1))
							phase_nxt = PH_SS;
					end
					res_cnt = 2'd1;
				end
				PH_SS: begin
					res_slot[0] = make_res(EV_SPEC_ST, VALUE_W'(b), '0, '0, 1'b0);
					res_cnt     = 2'd1;
					phase_nxt   = PH_SE;
				end
				PH_SE: begin
					res_slot[0] = make_res(EV_SPEC_END, VALUE_W'(b), '0, '0, 1'b0);
					res_cnt     = 2'd1;
					phase_nxt   = PH_APPROX;
				end
				PH_APPROX: begin
					res_slot[0]   = make_res(EV_APPROX, VALUE_W'(b), b[7:4], b[3:0], 1'b0);
					res_cnt       = 2'd1;
					skip_left_nxt = skip_calc;
					seg_len_nxt   = '0;
					after_ff_nxt  = 1'b0;
					if (skip_calc != '0) begin
						phase_nxt = PH_SKIP;
						if (!byte_stream.end_of_data) begin
							res_slot[1] = make_res(EV_SKIPPED, VALUE_W'(skip_calc), '0, '0, 1'b0);
							res_cnt     = 2'd2;
						end
					end else begin
						phase_nxt = PH_ENTROPY;
					end
				end
				PH_SKIP: begin
					skip_left_nxt = skip_left_q - 1'b1;
					if (skip_left_q == HDR_W'(1))
						phase_nxt = PH_ENTROPY;
				end
				PH_ENTROPY: begin
					if (after_ff_q) begin
						after_ff_nxt = 1'b0;
						if (b == STUFF_BYTE) begin
							seg_len_nxt = seg_add(seg_len_q, 2'd2);
						end else if (b[7:3] == RST_TOP_BITS) begin
							res_slot[0] = make_res(EV_SEGMENT, seg_to_value(seg_len_q), '0, '0,
								1'b0);
							res_slot[1] = make_res(EV_RESTART, VALUE_W'(b[2:0]), '0, '0, 1'b0);
							res_cnt     = 2'd2;
							seg_len_nxt = '0;
						end else begin
							res_slot[0]   = make_res(EV_SEGMENT, seg_to_value(seg_len_q), '0, '0,
								1'b0);
							res_slot[1]   = make_res(EV_END_MARK, VALUE_W'(b), '0, '0, 1'b1);
							res_cnt       = 2'd2;
							phase_nxt     = PH_IDLE;
							hdr_len_nxt   = '0;
							hdr_used_nxt  = HDR_FIXED_BYTES;
							comp_left_nxt = '0;
							second_nxt    = 1'b0;
							skip_left_nxt = '0;
							seg_len_nxt   = '0;
						end
					end else if (b == MARKER_PREFIX) begin
						after_ff_nxt = 1'b1;
					end else begin
						seg_len_nxt = seg_add(seg_len_q, 2'd1);
					end
				end
				default: begin
				end
			endcase
		end

		// Data ends while a scan is open: close it with an error result.
		if (byte_stream.end_of_data && (phase_nxt != PH_IDLE)) begin
			if (phase_nxt == PH_ENTROPY) begin
				if (res_cnt == 2'd2)
					res_cnt = 2'd1;
				res_slot[res_cnt[0]] = make_res(EV_EOF_ERR, seg_to_value(seg_len_nxt), '0, '0,
					1'b1);
			end else begin
				res_slot[res_cnt[0]] = make_res(EV_TRUNCATED, '0, '0, '0, 1'b1);
			end
			res_cnt       = res_cnt + 2'd1;
			phase_nxt     = PH_IDLE;
			hdr_len_nxt   = '0;
			hdr_used_nxt  = HDR_FIXED_BYTES;
			comp_left_nxt = '0;
			second_nxt    = 1'b0;
			skip_left_nxt = '0;
			seg_len_nxt   = '0;
			after_ff_nxt  = 1'b0;
		end
	end

	// Parser state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			hdr_len_q   <= '0;
			hdr_used_q  <= HDR_FIXED_BYTES;
			comp_left_q <= '0;
			second_q    <= 1'b0;
			skip_left_q <= '0;
			seg_len_q   <= '0;
			after_ff_q  <= 1'b0;
		end else if (in_acc) begin
			phase_q     <= phase_nxt;
			hdr_len_q   <= hdr_len_nxt;
			hdr_used_q  <= hdr_used_nxt;
			comp_left_q <= comp_left_nxt;
			second_q    <= second_nxt;
			skip_left_q <= skip_left_nxt;
			seg_len_q   <= seg_len_nxt;
			after_ff_q  <= after_ff_nxt;
		end
	end

	// Result queue storage: up to two writes per transaction.
	always_ff @(posedge clk) begin
		if (in_acc && (res_cnt != 2'd0))
			queue_q[wr_ptr_q] <= res_slot[0];
		if (in_acc && (res_cnt == 2'd2))
			queue_q[wr_ptr_q + 1'b1] <= res_slot[1];
	end

	// Result queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_acc)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(res_cnt);
			if (out_acc)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + (in_acc ? QCNT_W'(res_cnt) : '0) - QCNT_W'(out_acc);
		end
	end

	// Head of the queue drives the result channel.
	assign result_stream.valid       = (count_q != '0);
	assign result_stream.event_res   = queue_q[rd_ptr_q].event_res;
	assign result_stream.value       = queue_q[rd_ptr_q].value;
	assign result_stream.high_nibble = queue_q[rd_ptr_q].high_nibble;
	assign result_stream.low_nibble  = queue_q[rd_ptr_q].low_nibble;
	assign result_stream.scan_done   = queue_q[rd_ptr_q].scan_done;

`ifndef SYNTHESIS
	// The queue never holds more than its depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("result queue overfilled");

	// While components are being parsed at least one remains.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_COMP) |-> (comp_left_q != '0))
		else $error("component phase with no components left");

	// While skipping at least one byte remains to be skipped.
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SKIP) |-> (skip_left_q != '0))
		else $error("skip phase with nothing to skip");

	// A transaction that closes the scan leaves the parser idle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !byte_stream.scan_start && (res_cnt != 2'd0) &&
		(res_slot[res_cnt[1] ? 1 : 0].scan_done)) |=> (phase_q == PH_IDLE))
		else $error("scan closed but parser not idle");
`endif

endmodule

### dv/jpeg_scan_header_entropy_scanner_tb.sv
// ----------------------------------------------------------------------------
// Start-of-scan parser and entropy scanner testbench
// Feeds JPEG scan segments byte by byte: a short table of hand-picked bytes,
// then random scans with well-formed headers and entropy data, broken and cut
// short now and then. Every accepted byte advances a behavioural copy of the
// parser; its events or a row's typed ones are queued, checked field by field
// against each result transaction. The sender works in bursts, the receiver
// stalls in changing patterns and once holds off long enough to back up input.
// ----------------------------------------------------------------------------
module jpeg_scan_header_entropy_scanner_tb;
	import jsc_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_BYTES   = 1300;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 400;
	localparam int HOLD_AFTER     = 500;
	localparam int DRAIN_CYCLES   = 16;

	// Number of typed expectations in a stimulus row; this code means the
	// expectation comes from the parser copy instead.
	localparam logic [1:0] PREDICT = 2'd3;

	// One byte transaction with up to two typed expectations.
	typedef struct packed {
		logic [BYTE_W-1:0]  data;
		logic               start;
		logic               last;
		logic [1:0]         typed_n;
		jsc_event_t         ev0;
		logic [VALUE_W-1:0] val0;
		logic               done0;
		jsc_event_t         ev1;
		logic [VALUE_W-1:0] val1;
		logic               done1;
	} byte_item_t;

	localparam int DIR_ROWS = 26;

	// Hand-picked bytes: idle bytes, an extreme length cut off by a new scan,
	// a one-component scan with surplus header bytes, stuffing, a restart and
	// an FF fill byte taken as end marker, then a scan cut short at once.
	localparam byte_item_t DIRECTED [DIR_ROWS] = '{
		'{8'h00, 1'b0, 1'b0, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b1, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd1, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd1, EV_SPEC_ST, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h3F, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h0A, 1'b0, 1'b0, 2'd0, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h01, 1'b0, 1'b0, 2'd1, EV_COUNT, 24'd1, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd1, EV_SELECTOR, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, 2'd1, EV_SPEC_ST, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h3F, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h12, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h34, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h11, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'h00, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hD7, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, PREDICT, EV_COUNT, 24'd0, 1'b0, EV_COUNT, 24'd0, 1'b0},
		'{8'hFF, 1'b0, 1'b0, 2'd2, EV_SEGMENT, 24'd0, 1'b0, EV_END_MARK, 24'hFF, 1'b1},
		'{8'h00, 1'b1, 1'b1, 2'd1, EV_TRUNCATED, 24'd0, 1'b1, EV_COUNT, 24'd0, 1'b0}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	jsc_in_if  byte_ch ();
	jsc_out_if res_ch ();

	jpeg_scan_header_entropy_scanner DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.byte_stream   (byte_ch),
		.result_stream (res_ch)
	);

	always #2 clk = ~clk;

	byte_item_t  stim_q [$];
	jsc_result_t events_due [$];
	int          bytes_taken = 0;
	int          results_seen = 0;
	int          scans_built = 0;
	int          fail_cnt = 0;
	int          ev_seen [16];

	// Parser copy: scan state and the events raised by the current byte.
	jsc_phase_t          p_phase;
	logic [HDR_W-1:0]    p_hdr_len;
	logic [HDR_W-1:0]    p_hdr_used;
	logic [HDR_W-1:0]    p_skip_left;
	logic [COMP_W-1:0]   p_comp_left;
	logic                p_second;
	logic                p_after_ff;
	logic [SEG_BITS-1:0] p_seg_len;
	jsc_result_t         step_res [2];
	int                  step_n;

	function automatic void clear_scan();
		p_phase     = PH_IDLE;
		p_hdr_len   = '0;
		p_hdr_used  = HDR_FIXED_BYTES;
		p_skip_left = '0;
		p_comp_left = '0;
		p_second    = 1'b0;
		p_after_ff  = 1'b0;
		p_seg_len   = '0;
	endfunction

	function automatic void emit(jsc_event_t ev, logic [VALUE_W-1:0] val,
			logic [NIBBLE_W-1:0] hi, logic [NIBBLE_W-1:0] lo, logic done);
		step_res[step_n] = '{event_res: ev, value: val, high_nibble: hi,
			low_nibble: lo, scan_done: done};
		step_n++;
	endfunction

	// The segment counter stops at its all-ones value.
	function automatic void seg_add(int unsigned k);
		longint unsigned top;
		longint unsigned sum;
		top = (64'd1 << SEG_BITS) - 1;
		sum = 64'(p_seg_len);
		sum = sum + 64'(k);
		p_seg_len = (sum > top) ? top[SEG_BITS-1:0] : sum[SEG_BITS-1:0];
	endfunction

	// The reported length stops at the largest value field content.
	function automatic logic [VALUE_W-1:0] seg_report();
		longint unsigned s;
		s = 64'(p_seg_len);
		return (s > 64'hFFFFFF) ? 24'hFFFFFF : s[VALUE_W-1:0];
	endfunction

	// Advances the parser copy by one byte and collects the events it raises.
	function automatic void parse_byte(logic [BYTE_W-1:0] b, logic st, logic eod);
		step_n = 0;
		if (st) begin
			clear_scan();
			p_hdr_len = {b, 8'h00};
			p_phase   = PH_LEN_LO;
		end else begin
			case (p_phase)
				PH_LEN_LO: begin
					p_hdr_len[7:0] = b;
					p_phase = PH_COUNT;
				end
				PH_COUNT: begin
					p_comp_left = b;
					p_hdr_used  = HDR_FIXED_BYTES + (16'(b) << 1);
					p_second    = 1'b0;
					emit(EV_COUNT, VALUE_W'(b), '0, '0, 1'b0);
					p_phase = (b != 0) ? PH_COMP : PH_SS;
				end
				PH_COMP: begin
					if (!p_second) begin
						emit(EV_SELECTOR, VALUE_W'(b), '0, '0, 1'b0);
						p_second = 1'b1;
					end else begin
						emit(EV_TABLES, VALUE_W'(b), b[7:4], b[3:0], 1'b0);
						p_second = 1'b0;
						p_comp_left = p_comp_left - 1'b1;
						if (p_comp_left == 0)
							p_phase = PH_SS;
					end
				end
				PH_SS: begin
					emit(EV_SPEC_ST, VALUE_W'(b), '0, '0, 1'b0);
					p_phase = PH_SE;
				end
				PH_SE: begin
					emit(EV_SPEC_END, VALUE_W'(b), '0, '0, 1'b0);
					p_phase = PH_APPROX;
				end
				PH_APPROX: begin
					emit(EV_APPROX, VALUE_W'(b), b[7:4], b[3:0], 1'b0);
					p_skip_left = (p_hdr_len > p_hdr_used) ? p_hdr_len - p_hdr_used : '0;
					p_seg_len   = '0;
					p_after_ff  = 1'b0;
					if (p_skip_left != 0) begin
						p_phase = PH_SKIP;
						// A skip count is not reported when the data ends here.
						if (!eod)
							emit(EV_SKIPPED, VALUE_W'(p_skip_left), '0, '0, 1'b0);
					end else begin
						p_phase = PH_ENTROPY;
					end
				end
				PH_SKIP: begin
					p_skip_left = p_skip_left - 1'b1;
					if (p_skip_left == 0)
						p_phase = PH_ENTROPY;
				end
				PH_ENTROPY: begin
					if (p_after_ff) begin
						p_after_ff = 1'b0;
						if (b == STUFF_BYTE) begin
							seg_add(2);
						end else if (b[7:3] == RST_TOP_BITS) begin
							emit(EV_SEGMENT, seg_report(), '0, '0, 1'b0);
							emit(EV_RESTART, VALUE_W'(b[2:0]), '0, '0, 1'b0);
							p_seg_len = '0;
						end else begin
							emit(EV_SEGMENT, seg_report(), '0, '0, 1'b0);
							emit(EV_END_MARK, VALUE_W'(b), '0, '0, 1'b1);
							clear_scan();
						end
					end else if (b == MARKER_PREFIX) begin
						p_after_ff = 1'b1;
					end else begin
						seg_add(1);
					end
				end
				default: begin
				end
			endcase
		end

		// End of data inside a scan: a restart finished on the last byte loses
		// its restart event, and the length reported is the fresh one.
		if (eod && p_phase != PH_IDLE) begin
			if (p_phase == PH_ENTROPY) begin
				if (step_n == 2)
					step_n = 1;
				emit(EV_EOF_ERR, seg_report(), '0, '0, 1'b1);
			end else begin
				emit(EV_TRUNCATED, '0, '0, '0, 1'b1);
			end
			clear_scan();
		end
	endfunction

	// Books an accepted byte: typed expectations where the row has them,
	// otherwise the events of the parser copy.
	function automatic void take_byte(byte_item_t it);
		parse_byte(it.data, it.start, it.last);
		if (it.typed_n == PREDICT) begin
			for (int i = 0; i < step_n; i++)
				events_due.push_back(step_res[i]);
		end else begin
			if (it.typed_n >= 2'd1)
				events_due.push_back('{event_res: it.ev0, value: it.val0,
					high_nibble: '0, low_nibble: '0, scan_done: it.done0});
			if (it.typed_n == 2'd2)
				events_due.push_back('{event_res: it.ev1, value: it.val1,
					high_nibble: '0, low_nibble: '0, scan_done: it.done1});
		end
		bytes_taken++;
	endfunction

	function automatic byte_item_t mk_item(logic [BYTE_W-1:0] b, logic st, logic eod);
		byte_item_t it;
		it = '0;
		it.data    = b;
		it.start   = st;
		it.last    = eod;
		it.typed_n = PREDICT;
		return it;
	endfunction

	// Builds one random scan and returns the number of its bytes. Half the scans
	// end on an end marker, some on a bare FF or a restart, some are cut short
	// anywhere, and some are simply abandoned for the next scan.
	function automatic int add_scan();
		byte_item_t        body [$];
		byte_item_t        tmp;
		int                n_comp;
		int                extra;
		int                approx_idx;
		int                hdr_last;
		int                cut;
		int                n_data;
		logic [HDR_W-1:0]  used;
		logic [HDR_W-1:0]  len;
		logic [BYTE_W-1:0] mk;
		logic              eod;

		n_comp = ($urandom_range(0, 59) == 0) ? $urandom_range(5, 255) : $urandom_range(0, 4);
		used = HDR_FIXED_BYTES + 16'(2 * n_comp);
		if ($urandom_range(0, 7) == 0)
			len = 16'($urandom_range(0, used));
		else
			len = used + 16'($urandom_range(0, 3));
		extra = (len > used) ? int'(len - used) : 0;

		body.push_back(mk_item(len[15:8], 1'b1, 1'b0));
		body.push_back(mk_item(len[7:0], 1'b0, 1'b0));
		body.push_back(mk_item(n_comp[7:0], 1'b0, 1'b0));
		for (int i = 0; i < 2 * n_comp + 3; i++)
			body.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
		approx_idx = body.size() - 1;
		for (int i = 0; i < extra; i++)
			body.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0, 1'b0));
		hdr_last = body.size() - 1;

		// Entropy data with stuffing and restart markers mixed in.
		n_data = $urandom_range(0, 12);
		for (int i = 0; i < n_data; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				body.push_back(mk_item(MARKER_PREFIX, 1'b0, 1'b0));
				if ($urandom_range(0, 1) != 0)
					body.push_back(mk_item(STUFF_BYTE, 1'b0, 1'b0));
				else
					body.push_back(mk_item({RST_TOP_BITS, 3'($urandom_range(0, 7))},
						1'b0, 1'b0));
			end else begin
				body.push_back(mk_item(8'($urandom_range(0, 254)), 1'b0, 1'b0));
			end
		end

		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				if ($urandom_range(0, 1) != 0) begin
					mk = 8'hD9;
				end else begin
					mk = 8'($urandom_range(1, 255));
					while (mk[7:3] == RST_TOP_BITS)
						mk = 8'($urandom_range(1, 255));
				end
				eod = ($urandom_range(0, 9) == 0);
				body.push_back(mk_item(MARKER_PREFIX, 1'b0, 1'b0));
				body.push_back(mk_item(mk, 1'b0, eod));
			end
			5: body.push_back(mk_item(MARKER_PREFIX, 1'b0, 1'b1));
			6: begin
				body.push_back(mk_item(MARKER_PREFIX, 1'b0, 1'b0));
				body.push_back(mk_item({RST_TOP_BITS, 3'($urandom_range(0, 7))}, 1'b0, 1'b1));
			end
			7, 8: begin
				if (body.size() == 0)
					cut = 0;
				else if ($urandom_range(0, 1) != 0)
					cut = ($urandom_range(0, 1) != 0) ? approx_idx : hdr_last;
				else
					cut = $urandom_range(0, body.size() - 1);
				while (body.size() > cut + 1)
					void'(body.pop_back());
				tmp = body[cut];
				tmp.last = 1'b1;
				body[cut] = tmp;
			end
			default: begin
			end
		endcase

		foreach (body[i])
			stim_q.push_back(body[i]);
		scans_built++;

		// Stray bytes between scans; the parser ignores them when idle.
		if ($urandom_range(0, 3) == 0)
			repeat ($urandom_range(1, 3))
				stim_q.push_back(mk_item(8'($urandom_range(0, 255)), 1'b0,
					($urandom_range(0, 3) == 0)));
		return body.size();
	endfunction

	function automatic void check_field(string field, logic [VALUE_W-1:0] want,
			logic [VALUE_W-1:0] got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fail_cnt++;
		end
	endfunction

	// Byte sender: bursts of random length separated by random gaps. A byte
	// on offer is held until its transaction completes.
	initial begin : byte_sender
		byte_item_t cur;
		int         next_idx;
		int         burst_left;
		int         gap_left;
		logic       offer;

		cur        = '0;
		next_idx   = 0;
		burst_left = 1;
		gap_left   = 0;
		offer      = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.data_byte   = '0;
		byte_ch.scan_start  = 1'b0;
		byte_ch.end_of_data = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			offer = byte_ch.valid;
			if (byte_ch.valid && byte_ch.ready) begin
				take_byte(cur);
				offer = 1'b0;
			end
			if (!offer) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (next_idx < stim_q.size()) begin
					cur = stim_q[next_idx];
					next_idx++;
					offer = 1'b1;
					burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end
			end
			byte_ch.valid       <= offer;
			byte_ch.data_byte   <= cur.data;
			byte_ch.scan_start  <= cur.start;
			byte_ch.end_of_data <= cur.last;
		end
	end

	// Result receiver: checks each transaction against the oldest expected
	// event, and stalls in modes of random length. Once, a long hold-off lets
	// the result queue fill so that the byte port backs up.
	initial begin : result_receiver
		jsc_result_t want;
		int          mode;
		int          mode_left;
		int          hold_left;
		logic        hold_done;
		logic        rdy;

		mode      = 0;
		mode_left = 0;
		hold_left = 0;
		hold_done = 1'b0;
		rdy       = 1'b0;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready) begin
				results_seen++;
				ev_seen[res_ch.event_res]++;
				if (events_due.size() == 0) begin
					$error("unexpected result: event_res %0d, value %0d",
						res_ch.event_res, res_ch.value);
					fail_cnt++;
				end else begin
					want = events_due.pop_front();
					check_field("event_res", VALUE_W'(want.event_res),
						VALUE_W'(res_ch.event_res));
					check_field("value", want.value, res_ch.value);
					check_field("high_nibble", VALUE_W'(want.high_nibble),
						VALUE_W'(res_ch.high_nibble));
					check_field("low_nibble", VALUE_W'(want.low_nibble),
						VALUE_W'(res_ch.low_nibble));
					check_field("scan_done", VALUE_W'(want.scan_done),
						VALUE_W'(res_ch.scan_done));
				end
			end

			if (!hold_done && bytes_taken >= HOLD_AFTER) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else begin
				if (mode_left == 0) begin
					mode      = $urandom_range(0, 2);
					mode_left = $urandom_range(5, 60);
				end
				mode_left--;
				case (mode)
					0: rdy = 1'b1;
					1: rdy = ($urandom_range(0, 1) != 0);
					default: rdy = ($urandom_range(0, 3) == 0);
				endcase
			end
			res_ch.ready <= rdy;
		end
	end

	// Watchdog: ends the run when neither port has moved for too long.
	int idle_cycles = 0;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((byte_ch.valid && byte_ch.ready) || (res_ch.valid && res_ch.ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("Verification failed");
				$finish;
			end
		end
	end

	// Run control: build the stimulus, release reset, wait for the last
	// expected event, then report.
	initial begin : run_control
		int random_bytes;

		random_bytes = 0;
		clear_scan();
		step_n = 0;
		foreach (ev_seen[i])
			ev_seen[i] = 0;
		foreach (DIRECTED[i])
			stim_q.push_back(DIRECTED[i]);
		while (random_bytes < RANDOM_BYTES)
			random_bytes += add_scan();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (bytes_taken < stim_q.size() || events_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d bytes over %0d random scans, %0d results checked.",
			bytes_taken, scans_built, results_seen);
		$display("Summary: %0d restarts, %0d end markers, %0d data-end errors, %0d truncations.",
			ev_seen[EV_RESTART], ev_seen[EV_END_MARK], ev_seen[EV_EOF_ERR],
			ev_seen[EV_TRUNCATED]);
		if (fail_cnt == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

### filelist.f
rtl/core/jsc_pkg.sv
rtl/core/jsc_in_if.sv
rtl/core/jsc_out_if.sv
rtl/core/jpeg_scan_header_entropy_scanner.sv
dv/jpeg_scan_header_entropy_scanner_tb.sv
